// ----- rtl/core/rebq_pkg.sv -----
package rebq_pkg;

  localparam int unsigned TIMER_BITS = 20;
  localparam int unsigned CFG_BITS   = 20;
  localparam int unsigned POSITIONS  = 4;
  localparam int unsigned POS_BITS   = 2;
  localparam int unsigned LED_BITS   = 4;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam int unsigned US_PER_MS = 1000;
  localparam logic [CFG_BITS-1:0] ROTARY_LOCKOUT_RST = CFG_BITS'(15 * US_PER_MS);
  localparam logic [CFG_BITS-1:0] STABLE_WINDOW_RST  = CFG_BITS'(8 * US_PER_MS);
  localparam logic [CFG_BITS-1:0] BUTTON_LOCKOUT_RST = CFG_BITS'(150 * US_PER_MS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    RegRotaryLockout = 2'd0,
    RegStableWindow  = 2'd1,
    RegButtonLockout = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvUp     = 2'd1,
    EvDown   = 2'd2,
    EvToggle = 2'd3
  } event_e;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic button_level;
  } in_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                enabled;
    logic [LED_BITS-1:0] red_leds;
    logic                green_led;
    logic [1:0]          event_res;
    logic                busy_res;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] rotary_lockout;
    logic [CFG_BITS-1:0] stable_window;
    logic [CFG_BITS-1:0] button_lockout;
  } cfg_t;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == TIMER_MAX) ? TIMER_MAX : v + TIMER_BITS'(1);
  endfunction

endpackage

// ----- rtl/core/rebq_cfg.sv -----
module rebq_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rebq_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rebq_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  output rebq_pkg::cfg_t                      cfg_o
);
  import rebq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRotaryLockout: cfg_d.rotary_lockout = cfg_wdata_i;
        RegStableWindow:  cfg_d.stable_window  = cfg_wdata_i;
        RegButtonLockout: cfg_d.button_lockout = cfg_wdata_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotary_lockout <= ROTARY_LOCKOUT_RST;
      cfg_q.stable_window  <= STABLE_WINDOW_RST;
      cfg_q.button_lockout <= BUTTON_LOCKOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/rebq_core.sv -----
module rebq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  rebq_pkg::in_item_t   item_i,
  input  rebq_pkg::cfg_t       cfg_i,
  output rebq_pkg::out_item_t  result_o
);
  import rebq_pkg::*;

  typedef enum logic [5:0] {
    PhIdle = 6'b000001,
    PhUpB  = 6'b000010,
    PhUpA  = 6'b000100,
    PhDnA  = 6'b001000,
    PhDnB  = 6'b010000,
    PhBtn  = 6'b100000
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [2:0]            prev_q, prev_d;      // {button, b, a}
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic                  en_q, en_d;
  logic [TIMER_BITS-1:0] rot_q, rot_d;
  logic [TIMER_BITS-1:0] btn_q, btn_d;
  logic [TIMER_BITS-1:0] wc_q, wc_d;
  logic                  first_q, first_d;

  logic [TIMER_BITS-1:0] rot_inc, btn_inc, wc_inc;
  logic                  level, waiting, mismatch, qual_lo, qual_hi;
  logic                  fall_a, fall_b, rise_btn, rot_ok, btn_ok;
  event_e                ev;

  assign rot_inc = sat_inc(rot_q);
  assign btn_inc = sat_inc(btn_q);
  assign wc_inc  = sat_inc(wc_q);

  always_comb begin
    case (phase_q)
      PhUpB, PhDnB: level = item_i.pin_b;
      PhUpA, PhDnA: level = item_i.pin_a;
      default:      level = item_i.button_level;
    endcase
  end

  assign waiting  = (wc_inc < TIMER_BITS'(cfg_i.stable_window)) && (wc_inc != TIMER_MAX);
  assign mismatch = level != first_q;
  assign qual_lo  = !waiting && !mismatch && !first_q;
  assign qual_hi  = !waiting && !mismatch && first_q;

  assign rot_ok   = rot_inc > TIMER_BITS'(cfg_i.rotary_lockout);
  assign btn_ok   = btn_inc > TIMER_BITS'(cfg_i.button_lockout);
  assign fall_a   = prev_q[0] && !item_i.pin_a;
  assign fall_b   = prev_q[1] && !item_i.pin_b;
  assign rise_btn = !prev_q[2] && item_i.button_level;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    en_d    = en_q;
    rot_d   = rot_inc;
    btn_d   = btn_inc;
    wc_d    = wc_q;
    first_d = first_q;
    ev      = EvNone;
    prev_d  = {item_i.button_level, item_i.pin_b, item_i.pin_a};

    if (phase_q != PhIdle) begin
      wc_d = wc_inc;
      // second sample disagrees: restart the window from the newer sample
      if (!waiting && mismatch) begin
        first_d = level;
        wc_d    = '0;
      end
    end

    unique case (phase_q)
      PhUpB: begin
        if (qual_hi) begin
          phase_d = PhUpA;
          first_d = item_i.pin_a;
          wc_d    = '0;
        end else if (qual_lo) begin
          phase_d = PhIdle;
        end
      end
      PhUpA: begin
        if (qual_lo) begin
          pos_d = (pos_q == POS_BITS'(POSITIONS - 1)) ? '0 : pos_q + POS_BITS'(1);
          rot_d = '0;
          ev    = EvUp;
        end
        if (qual_lo || qual_hi) phase_d = PhIdle;
      end
      PhDnA: begin
        if (qual_hi) begin
          phase_d = PhDnB;
          first_d = item_i.pin_b;
          wc_d    = '0;
        end else if (qual_lo) begin
          phase_d = PhIdle;
        end
      end
      PhDnB: begin
        if (qual_lo) begin
          pos_d = (pos_q == '0) ? POS_BITS'(POSITIONS - 1) : pos_q - POS_BITS'(1);
          rot_d = '0;
          ev    = EvDown;
        end
        if (qual_lo || qual_hi) phase_d = PhIdle;
      end
      PhBtn: begin
        if (qual_hi) begin
          en_d  = !en_q;
          btn_d = '0;
          ev    = EvToggle;
        end
        if (qual_lo || qual_hi) phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
        if (fall_a && rot_ok) begin
          phase_d = PhUpB;
          first_d = item_i.pin_b;
          wc_d    = '0;
        end else if (fall_b && rot_ok) begin
          phase_d = PhDnA;
          first_d = item_i.pin_a;
          wc_d    = '0;
        end else if (rise_btn && btn_ok) begin
          phase_d = PhBtn;
          first_d = item_i.button_level;
          wc_d    = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      prev_q  <= 3'b011;
      pos_q   <= '0;
      en_q    <= 1'b0;
      rot_q   <= '0;
      btn_q   <= '0;
      wc_q    <= '0;
      first_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      pos_q   <= pos_d;
      en_q    <= en_d;
      rot_q   <= rot_d;
      btn_q   <= btn_d;
      wc_q    <= wc_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    result_o.position  = pos_d;
    result_o.enabled   = en_d;
    result_o.red_leds  = en_d ? (LED_BITS'(1) << pos_d) : '0;
    result_o.green_led = !en_d;
    result_o.event_res = ev;
    result_o.busy_res  = phase_d != PhIdle;
  end

endmodule

// ----- rtl/core/rotary_encoder_button_qualifier_top.sv -----
// Channel | Direction | Signals                              | Handshake
// input   | in        | in_valid_i, in_ready_o, in_data_i    | valid/ready
// result  | out       | out_valid_o, out_ready_i, out_data_o | valid/ready
// config  | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i     | write enable, no wait
//
// One transaction per clock cycle sustained while the result is not stalled; each result
// is presented after its input passes the input register, then the result register.
// The tick logic is a single pass over the phase machine and three saturating counters.
// Reset restores the register defaults and clears the phase machine and both valid flags.
// A stalled result holds the result register; the input register keeps taking a
// new transaction whenever it empties into the result register in the same cycle.
module rotary_encoder_button_qualifier_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rebq_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rebq_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rebq_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [rebq_pkg::CFG_BITS-1:0]     cfg_wdata_i
);
  import rebq_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q, result;
  logic      out_valid_q, out_valid_d;
  logic      step;

  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign in_valid_d  = (in_valid_i && in_ready_o) || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  rebq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rebq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (step) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
